@@ sv/hptc_pkg.sv @@
// hptc_pkg: shared types, constants and helpers of the heading PID turn controller.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package hptc_pkg;

  // Fixed-point format and accumulator sizing
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int SUM_WIDTH       = 32;
  localparam int ANGLE_W         = 16;
  localparam int GAIN_W          = 16;
  localparam int LIM_W           = 15;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // Angle math is done two bits wider than an angle, so sums of three terms fit
  localparam int EXT_W   = ANGLE_W + 2;
  localparam int DER_W   = ANGLE_W + 1;
  localparam int PPROD_W = GAIN_W + 1 + ANGLE_W;
  localparam int IPROD_W = GAIN_W + 1 + SUM_WIDTH;
  localparam int DPROD_W = GAIN_W + 1 + DER_W;
  localparam int ACC_W   = IPROD_W + 2;
  localparam int PID_W   = ACC_W - ANGLE_FRAC_BITS;

  // pi and pi/2 in the angle format, rounded to nearest
  localparam longint PI_Q30    = 64'sd3373259426;
  localparam longint PI_Q      = (PI_Q30 + (64'sd1 << (29 - ANGLE_FRAC_BITS)))
                                 >>> (30 - ANGLE_FRAC_BITS);
  localparam longint HALF_PI_Q = (PI_Q30 + (64'sd1 << (30 - ANGLE_FRAC_BITS)))
                                 >>> (31 - ANGLE_FRAC_BITS);
  localparam logic signed [EXT_W-1:0] PI_C      = EXT_W'(PI_Q);
  localparam logic signed [EXT_W-1:0] HALF_PI_C = EXT_W'(HALF_PI_Q);

  // Item kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_MIN_DRIVE  = 3'd3,
    CFG_STOP_TOL   = 3'd4,
    CFG_SNAP_WIN   = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd6144;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd82;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd737;
  localparam logic [LIM_W-1:0]  MIN_DRIVE_RST  = 15'd819;
  localparam logic [LIM_W-1:0]  STOP_TOL_RST   = 15'd82;
  localparam logic [LIM_W-1:0]  SNAP_WIN_RST   = 15'd410;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  min_drive;
    logic [LIM_W-1:0]  stop_tolerance;
    logic [LIM_W-1:0]  snap_window;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angular_drive;
    logic                      done_res;
  } res_t;

  // Strict window test: c - w < t < c + w
  function automatic logic in_window(logic signed [EXT_W-1:0] c,
                                     logic signed [EXT_W-1:0] w,
                                     logic signed [EXT_W-1:0] t);
    return ((c - w) < t) && ((c + w) > t);
  endfunction

  // Clamp an extended angle value into the signed angle range
  function automatic logic signed [ANGLE_W-1:0] sat_angle(logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'({1'b0, {(ANGLE_W-1){1'b1}}});
    lo = -hi - EXT_W'(1);
    if (v > hi) return hi[ANGLE_W-1:0];
    if (v < lo) return lo[ANGLE_W-1:0];
    return v[ANGLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/hptc_in_if.sv @@
// hptc_in_if: input item channel (start or yaw sample) with valid/ready.
// Depends on hptc_pkg.
`default_nettype none

interface hptc_in_if;
  import hptc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [ANGLE_W-1:0] target_angle;
  logic signed [ANGLE_W-1:0] measured_yaw;

  modport source (output valid, kind, target_angle, measured_yaw, input ready);
  modport sink   (input valid, kind, target_angle, measured_yaw, output ready);
endinterface

`default_nettype wire

@@ sv/hptc_out_if.sv @@
// hptc_out_if: result item channel (drive and done flag) with valid/ready.
// Depends on hptc_pkg.
`default_nettype none

interface hptc_out_if;
  import hptc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angular_drive;
  logic                      done_res;

  modport source (output valid, angular_drive, done_res, input ready);
  modport sink   (input valid, angular_drive, done_res, output ready);
endinterface

`default_nettype wire

@@ sv/hptc_cfg.sv @@
// hptc_cfg: gain and limit register file written through a plain write port.
// Depends on hptc_pkg.
`default_nettype none

module hptc_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hptc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output hptc_pkg::cfg_t                      cfg_o
);
  import hptc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:  cfg_d.prop_gain      = cfg_wdata_i;
        CFG_INTEG_GAIN: cfg_d.integ_gain     = cfg_wdata_i;
        CFG_DERIV_GAIN: cfg_d.deriv_gain     = cfg_wdata_i;
        CFG_MIN_DRIVE:  cfg_d.min_drive      = cfg_wdata_i[LIM_W-1:0];
        CFG_STOP_TOL:   cfg_d.stop_tolerance = cfg_wdata_i[LIM_W-1:0];
        CFG_SNAP_WIN:   cfg_d.snap_window    = cfg_wdata_i[LIM_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= PROP_GAIN_RST;
      cfg_q.integ_gain     <= INTEG_GAIN_RST;
      cfg_q.deriv_gain     <= DERIV_GAIN_RST;
      cfg_q.min_drive      <= MIN_DRIVE_RST;
      cfg_q.stop_tolerance <= STOP_TOL_RST;
      cfg_q.snap_window    <= SNAP_WIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/hptc_core.sv @@
// hptc_core: controller state and the single-pass window/error/PID datapath.
// Depends on hptc_pkg; fed by the input register of the top level.
`default_nettype none

module hptc_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire hptc_pkg::cfg_t                     cfg_i,
  input  wire logic                               fire_i,
  input  wire logic                               kind_i,
  input  wire logic signed [hptc_pkg::ANGLE_W-1:0] target_i,
  input  wire logic signed [hptc_pkg::ANGLE_W-1:0] yaw_i,
  output hptc_pkg::res_t                          res_o
);
  import hptc_pkg::*;

  logic signed [ANGLE_W-1:0]   held_target_q, held_target_d;
  logic signed [SUM_WIDTH-1:0] error_sum_q, error_sum_d;
  logic signed [ANGLE_W-1:0]   prev_err_q, prev_err_d;
  logic signed [ANGLE_W-1:0]   cur_err_q, cur_err_d;
  logic signed [ANGLE_W-1:0]   held_drive_q, held_drive_d;

  logic signed [EXT_W-1:0]     t_x, y_x, w_x, e_x;
  logic                        matched, use_max;
  logic signed [ANGLE_W-1:0]   err, start_err, sample_err, drive_new;
  logic signed [DER_W-1:0]     deriv;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_new;
  logic signed [PPROD_W-1:0]   p_prop;
  logic signed [IPROD_W-1:0]   p_int;
  logic signed [DPROD_W-1:0]   p_der;
  logic signed [ACC_W-1:0]     acc;
  logic signed [PID_W-1:0]     pid, pid_lim, mag, drv_hi, drv_lo;
  logic [ANGLE_W:0]            abs_err;

  assign t_x = EXT_W'(held_target_q);
  assign y_x = EXT_W'(yaw_i);
  assign w_x = EXT_W'({1'b0, cfg_i.snap_window});

  // Pick the target window and form the wrapped error and drive sign
  always_comb begin
    matched = 1'b1;
    use_max = 1'b1;
    e_x     = t_x - y_x;
    if (in_window(PI_C, w_x, t_x)) begin
      if (y_x > 0) begin
        e_x = t_x - y_x;
        use_max = 1'b1;
      end else begin
        e_x = -(t_x + y_x);
        use_max = 1'b0;
      end
    end else if (in_window(HALF_PI_C, w_x, t_x)) begin
      if (y_x > 0) begin
        e_x = t_x - y_x;
        use_max = (y_x <= t_x);
      end else if ((y_x + PI_C) >= t_x) begin
        e_x = t_x - y_x;
        use_max = 1'b1;
      end else begin
        e_x = -(t_x + PI_C + y_x);
        use_max = 1'b0;
      end
    end else if (in_window(-HALF_PI_C, w_x, t_x)) begin
      if (y_x < 0) begin
        e_x = t_x - y_x;
        use_max = (y_x <= t_x);
      end else if ((y_x - PI_C) >= t_x) begin
        e_x = PI_C - y_x - t_x;
        use_max = 1'b1;
      end else begin
        e_x = t_x - y_x;
        use_max = 1'b0;
      end
    end else if (in_window('0, w_x, t_x)) begin
      e_x = t_x - y_x;
      use_max = !(y_x > 0);
    end else begin
      matched = 1'b0;
    end
  end

  assign err       = sat_angle(e_x);
  assign start_err = sat_angle(EXT_W'(target_i) - y_x);

  // Saturating integral
  assign sum_wide = (SUM_WIDTH+1)'(error_sum_q) + (SUM_WIDTH+1)'(err);
  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_new = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_new = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // PID terms and sum
  assign deriv  = DER_W'(err) - DER_W'(prev_err_q);
  assign p_prop = $signed({1'b0, cfg_i.prop_gain}) * err;
  assign p_int  = $signed({1'b0, cfg_i.integ_gain}) * sum_new;
  assign p_der  = $signed({1'b0, cfg_i.deriv_gain}) * deriv;
  assign acc    = ACC_W'(p_prop) + ACC_W'(p_int) + ACC_W'(p_der);
  assign pid    = acc[ACC_W-1:ANGLE_FRAC_BITS];

  // Enforce the minimum magnitude, then clamp to the drive range
  assign mag    = PID_W'({1'b0, cfg_i.min_drive});
  assign drv_hi = PID_W'({1'b0, {(ANGLE_W-1){1'b1}}});
  assign drv_lo = -drv_hi - PID_W'(1);
  always_comb begin
    pid_lim = pid;
    if (use_max) begin
      if (pid < mag) pid_lim = mag;
    end else begin
      if (pid > -mag) pid_lim = -mag;
    end
    if (pid_lim > drv_hi) begin
      drive_new = drv_hi[ANGLE_W-1:0];
    end else if (pid_lim < drv_lo) begin
      drive_new = drv_lo[ANGLE_W-1:0];
    end else begin
      drive_new = pid_lim[ANGLE_W-1:0];
    end
  end

  // Next state for a start or a sample item
  assign sample_err = matched ? err : cur_err_q;
  always_comb begin
    held_target_d = held_target_q;
    error_sum_d   = error_sum_q;
    prev_err_d    = prev_err_q;
    cur_err_d     = cur_err_q;
    held_drive_d  = held_drive_q;
    if (fire_i) begin
      if (kind_i == KIND_START) begin
        held_target_d = target_i;
        error_sum_d   = '0;
        prev_err_d    = '0;
        held_drive_d  = '0;
        cur_err_d     = start_err;
      end else begin
        if (matched) begin
          error_sum_d  = sum_new;
          held_drive_d = drive_new;
        end
        cur_err_d  = sample_err;
        prev_err_d = sample_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_target_q <= '0;
      error_sum_q   <= '0;
      prev_err_q    <= '0;
      cur_err_q     <= '0;
      held_drive_q  <= '0;
    end else begin
      held_target_q <= held_target_d;
      error_sum_q   <= error_sum_d;
      prev_err_q    <= prev_err_d;
      cur_err_q     <= cur_err_d;
      held_drive_q  <= held_drive_d;
    end
  end

  // Result of a sample item: zero drive once within tolerance
  assign abs_err = sample_err[ANGLE_W-1] ? (ANGLE_W+1)'(-(DER_W'(sample_err)))
                                         : (ANGLE_W+1)'(sample_err);
  assign res_o.done_res      = (abs_err <= (ANGLE_W+1)'(cfg_i.stop_tolerance));
  assign res_o.angular_drive = res_o.done_res ? '0
                             : (matched ? drive_new : held_drive_q);

endmodule

`default_nettype wire

@@ sv/heading_pid_turn_controller.sv @@
// heading_pid_turn_controller: top level; input register, controller core and
// result register. Depends on hptc_pkg, hptc_in_if, hptc_out_if, hptc_cfg, hptc_core.
//
//   channel   dir  handshake      payload
//   item_i    in   valid/ready    kind, target_angle, measured_yaw
//   result_o  out  valid/ready    angular_drive, done_res (one per yaw sample)
//   cfg_*     in   cfg_we_i       cfg_idx_i, cfg_wdata_i (six registers)
//
// One item per cycle while results are not stalled: an item waits in the input
// register, where the window test, error, integral and PID sum run in a single
// pass into the result register; a sample's result is loaded there as the item
// leaves the input register.
// A start item updates the state and gives no result.
// Reset clears the state and the valid flags and loads the register defaults.
// A stalled result holds the next sample in the input register; starts still pass.
`default_nettype none

module heading_pid_turn_controller (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  hptc_in_if.sink                             item_i,
  hptc_out_if.source                          result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [hptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hptc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import hptc_pkg::*;

  cfg_t                      cfg;
  res_t                      res;
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_kind_q;
  logic signed [ANGLE_W-1:0] s1_target_q, s1_yaw_q;
  logic                      out_valid_q, out_valid_d;
  res_t                      out_res_q;
  logic                      adv, take;

  hptc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the registered item when it needs no result slot or one is free
  assign adv  = s1_valid_q && ((s1_kind_q == KIND_START) || !out_valid_q || result_o.ready);
  assign take = item_i.valid && item_i.ready;
  assign item_i.ready = !s1_valid_q || adv;

  hptc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (adv),
    .kind_i   (s1_kind_q),
    .target_i (s1_target_q),
    .yaw_i    (s1_yaw_q),
    .res_o    (res)
  );

  // Input register
  assign s1_valid_d = take || (s1_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_kind_q   <= item_i.kind;
      s1_target_q <= item_i.target_angle;
      s1_yaw_q    <= item_i.measured_yaw;
    end
  end

  // Result register: load on a sample, drop once taken
  always_comb begin
    out_valid_d = out_valid_q && !result_o.ready;
    if (adv && (s1_kind_q == KIND_SAMPLE)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && (s1_kind_q == KIND_SAMPLE)) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.angular_drive = out_res_q.angular_drive;
  assign result_o.done_res      = out_res_q.done_res;

  // A sample leaving the input register always shows up as a result
  a_sample_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (s1_kind_q == KIND_SAMPLE)) |=> result_o.valid)
    else $error("sample advanced without a result");

  // A start never creates a result
  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (s1_kind_q == KIND_START) && !out_valid_q) |=> !result_o.valid)
    else $error("start item produced a result");

  // A sample blocked by a full result register stays put
  a_blocked_sample_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_kind_q == KIND_SAMPLE) && out_valid_q && !result_o.ready)
    |=> (s1_valid_q && $stable(s1_yaw_q)))
    else $error("blocked sample lost");

  // A finished turn commands no rotation
  a_done_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.done_res) |-> (result_o.angular_drive == '0))
    else $error("done result with nonzero drive");

endmodule

`default_nettype wire
